FILE: sv/ldm_pkg.sv
// Shared constants, codes and types of the LED module dot map.
package ldm_pkg;

    localparam int DOT_DEPTH = 1024;
    localparam int MAX_LINES = 32;
    localparam int AW        = $clog2(DOT_DEPTH);

    localparam int FULL_SPAN = 1024;
    localparam int BASE_MULT = 32;
    localparam int BASE_LOG  = $clog2(BASE_MULT);
    localparam int SW        = $clog2(BASE_LOG + 1);

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_MAP   = 2'd1;
    localparam logic [1:0] ACT_LINE  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] CFG_SCAN  = 2'd0;
    localparam logic [1:0] CFG_WIDTH = 2'd1;
    localparam logic [1:0] CFG_WRAP  = 2'd2;
    localparam logic [1:0] CFG_EMPTY = 2'd3;

    localparam int DIV_NW = 11;
    localparam int DIV_DW = 22;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    typedef struct packed {
        logic [7:0] row;
        logic [9:0] col;
    } t_dot;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

endpackage

FILE: sv/led_module_dot_map.sv
// LED module dot map: dot store, valid length derivation and entry sequencer.
//
//  channel | valid      | ready       | payload
//  input   | i_in_valid | o_in_ready  | i_action i_index i_dot_row i_dot_col
//  output  | o_out_valid| i_out_ready | o_value o_in_range o_data_valid_len o_view_valid_len
//  config  | i_cfg_valid| o_cfg_ready | i_cfg_index i_cfg_data
//
// One transaction at a time; degenerate settings skip every divider pass, and the sequencer
// returns to idle before the next acceptance. Each pass goes through the shared 11-step
// divider: one for the lengths, one per line adjust read, three per dot-map read (one when
// the dot-map read is out of range).
// Synchronous active-low reset clears the sequencer and the output valid flag and loads the
// default settings; the store needs no clearing. A result waiting in the output register holds
// only the final step; the next transaction is taken meanwhile.
module led_module_dot_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [9:0]  i_index,
    input  logic [7:0]  i_dot_row,
    input  logic [9:0]  i_dot_col,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_value,
    output logic        o_in_range,
    output logic [23:0] o_data_valid_len,
    output logic [23:0] o_view_valid_len,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_PRE  = 5'd1;
    localparam logic [4:0] S_LSH  = 5'd2;
    localparam logic [4:0] S_EXT  = 5'd3;
    localparam logic [4:0] S_D1S  = 5'd4;
    localparam logic [4:0] S_D1W  = 5'd5;
    localparam logic [4:0] S_MUL  = 5'd6;
    localparam logic [4:0] S_BR   = 5'd7;
    localparam logic [4:0] S_LRD  = 5'd8;
    localparam logic [4:0] S_LDW  = 5'd9;
    localparam logic [4:0] S_GS   = 5'd10;
    localparam logic [4:0] S_GW   = 5'd11;
    localparam logic [4:0] S_CHK  = 5'd12;
    localparam logic [4:0] S_CMP  = 5'd13;
    localparam logic [4:0] S_MRD  = 5'd14;
    localparam logic [4:0] S_MW   = 5'd15;
    localparam logic [4:0] S_WS   = 5'd16;
    localparam logic [4:0] S_WW   = 5'd17;
    localparam logic [4:0] S_A1   = 5'd18;
    localparam logic [4:0] S_A2   = 5'd19;
    localparam logic [4:0] S_DONE = 5'd20;

    localparam int LW = 16 + ldm_pkg::BASE_LOG;
    localparam int QW = 5 + ldm_pkg::BASE_LOG;

    logic [4:0]  r_state, n_state;
    logic [5:0]  r_sl;
    logic [10:0] r_mw;
    logic [4:0]  r_wt;
    logic [7:0]  r_ed;

    logic [1:0]  r_act;
    logic [9:0]  r_idx;
    logic        r_ok;
    logic [15:0] r_w;
    logic [16:0] r_p;
    logic [LW-1:0] r_l;
    logic [QW-1:0] r_q;
    logic [21:0] r_x;
    logic [10:0] r_n;
    logic [23:0] r_dlen;
    logic [23:0] r_vlen;
    logic [9:0]  r_grp;
    logic [16:0] r_r;
    logic [27:0] r_prod;
    logic [9:0]  r_col;
    logic [7:0]  r_rq;
    logic [10:0] r_qw;
    logic [15:0] r_acc;
    logic [15:0] r_val;
    logic        r_rok;

    logic        r_ov;
    logic [15:0] r_o_val;
    logic        r_o_rok;
    logic [23:0] r_o_dlen;
    logic [23:0] r_o_vlen;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_load;
    logic [ldm_pkg::SW-1:0] w_s;
    logic [25:0] w_d;
    logic        w_line_ok;
    logic        w_map_ok;

    logic                   w_wr_en;
    logic                   w_rd_en;
    logic [ldm_pkg::AW-1:0] w_rd_addr;
    ldm_pkg::t_dot          w_wr_data;
    ldm_pkg::t_dot          w_rd_data;
    ldm_pkg::t_div_req      w_div_req;
    ldm_pkg::t_div_rsp      w_div_rsp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = r_ov && i_out_ready;
    assign w_load      = (r_state == S_DONE) && (!r_ov || i_out_ready);

    always_comb begin
        w_s = ldm_pkg::SW'(ldm_pkg::BASE_LOG);
        for (int i = ldm_pkg::BASE_LOG - 1; i >= 0; i--) begin
            if (r_w[i]) begin
                w_s = ldm_pkg::SW'(i);
            end
        end
    end

    assign w_d       = 26'(r_idx * r_w);
    assign w_line_ok = r_ok && (32'(r_idx) < 32'(r_sl)) && (32'(r_idx) < ldm_pkg::MAX_LINES)
                       && (32'(w_d) < ldm_pkg::DOT_DEPTH);
    assign w_map_ok  = (r_prod <= 28'(r_vlen)) && (32'(r_r) < ldm_pkg::DOT_DEPTH);

    assign w_wr_en       = w_in_acc && (i_action == ldm_pkg::ACT_WRITE)
                           && (32'(i_index) < ldm_pkg::DOT_DEPTH);
    assign w_wr_data.row = i_dot_row;
    assign w_wr_data.col = i_dot_col;

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = ldm_pkg::AW'(w_d);
        if (r_state == S_BR && r_act == ldm_pkg::ACT_LINE && w_line_ok) begin
            w_rd_en = 1'b1;
        end else if (r_state == S_CMP && w_map_ok) begin
            w_rd_en   = 1'b1;
            w_rd_addr = ldm_pkg::AW'(r_r);
        end
    end

    always_comb begin
        w_div_req.start = 1'b0;
        w_div_req.num   = ldm_pkg::DIV_NW'(ldm_pkg::FULL_SPAN);
        w_div_req.den   = r_x;
        case (r_state)
            S_D1S: begin
                w_div_req.start = 1'b1;
            end
            S_LRD, S_MRD: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = ldm_pkg::DIV_NW'(w_rd_data.row);
                w_div_req.den   = ldm_pkg::DIV_DW'(r_sl);
            end
            S_GS: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = ldm_pkg::DIV_NW'(r_idx);
                w_div_req.den   = ldm_pkg::DIV_DW'(r_p);
            end
            S_WS: begin
                w_div_req.start = 1'b1;
                w_div_req.den   = ldm_pkg::DIV_DW'(r_wt);
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_PRE;
            S_PRE:  n_state = S_LSH;
            S_LSH:  n_state = S_EXT;
            S_EXT:  n_state = r_ok ? S_D1S : S_DONE;
            S_D1S:  n_state = S_D1W;
            S_D1W:  if (w_div_rsp.done) n_state = S_MUL;
            S_MUL:  n_state = S_BR;
            S_BR: begin
                if (r_act == ldm_pkg::ACT_LINE) begin
                    n_state = w_line_ok ? S_LRD : S_DONE;
                end else if (r_act == ldm_pkg::ACT_MAP) begin
                    n_state = S_GS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LRD:  n_state = S_LDW;
            S_LDW:  if (w_div_rsp.done) n_state = S_DONE;
            S_GS:   n_state = S_GW;
            S_GW:   if (w_div_rsp.done) n_state = S_CHK;
            S_CHK:  n_state = S_CMP;
            S_CMP:  n_state = w_map_ok ? S_MRD : S_DONE;
            S_MRD:  n_state = S_MW;
            S_MW:   if (w_div_rsp.done) n_state = S_WS;
            S_WS:   n_state = S_WW;
            S_WW:   if (w_div_rsp.done) n_state = S_A1;
            S_A1:   n_state = S_A2;
            S_A2:   n_state = S_DONE;
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sl    <= 6'd16;
            r_mw    <= 11'd64;
            r_wt    <= 5'd1;
            r_ed    <= 8'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ldm_pkg::CFG_SCAN:  r_sl <= i_cfg_data[5:0];
                    ldm_pkg::CFG_WIDTH: r_mw <= i_cfg_data;
                    ldm_pkg::CFG_WRAP:  r_wt <= i_cfg_data[4:0];
                    ldm_pkg::CFG_EMPTY: r_ed <= i_cfg_data[7:0];
                    default: r_ed <= r_ed;
                endcase
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (w_out_acc) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_act <= i_action;
                    r_idx <= i_index;
                end
            end
            S_PRE: begin
                r_ok  <= (r_sl != '0) && (r_mw != '0) && (r_wt != '0);
                r_w   <= 16'(r_mw * r_wt);
                r_p   <= 17'((12'(r_mw) + 12'(r_ed)) * r_wt);
                r_val <= '0;
                r_rok <= 1'b0;
            end
            S_LSH: begin
                r_l <= LW'(r_w) << (ldm_pkg::SW'(ldm_pkg::BASE_LOG) - w_s);
                r_q <= {r_wt, {ldm_pkg::BASE_LOG{1'b0}}} >> w_s;
            end
            S_EXT: begin
                r_x <= 22'(r_l) + 22'(r_q * r_ed);
                if (!r_ok) begin
                    r_dlen <= '0;
                    r_vlen <= '0;
                end
            end
            S_D1W: begin
                if (w_div_rsp.done) begin
                    r_n <= (w_div_rsp.quo == '0) ? 11'd1 : w_div_rsp.quo;
                end
            end
            S_MUL: begin
                r_dlen <= 24'(r_l * r_n);
                r_vlen <= 24'(r_x * r_n);
            end
            S_LDW: begin
                if (w_div_rsp.done) begin
                    r_val <= 16'(w_div_rsp.rem);
                    r_rok <= 1'b1;
                end
            end
            S_GW: begin
                if (w_div_rsp.done) begin
                    r_grp <= 10'(w_div_rsp.quo);
                    r_r   <= 17'(w_div_rsp.rem);
                end
            end
            S_CHK: begin
                r_prod <= 28'((11'(r_grp) + 11'd1) * r_p);
            end
            S_MRD: begin
                r_col <= w_rd_data.col;
            end
            S_MW: begin
                if (w_div_rsp.done) begin
                    r_rq <= 8'(w_div_rsp.quo);
                end
            end
            S_WW: begin
                if (w_div_rsp.done) begin
                    r_qw <= w_div_rsp.quo;
                end
            end
            S_A1: begin
                r_acc <= 16'(r_grp * r_mw) + 16'(r_col);
            end
            S_A2: begin
                r_val <= r_acc + 16'(r_rq * r_qw);
                r_rok <= 1'b1;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        if (w_load) begin
            r_o_val  <= r_val;
            r_o_rok  <= r_rok;
            r_o_dlen <= r_dlen;
            r_o_vlen <= r_vlen;
        end
    end

    ldm_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (ldm_pkg::AW'(i_index)),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ldm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_out_valid      = r_ov;
    assign o_value          = r_o_val;
    assign o_in_range       = r_o_rok;
    assign o_data_valid_len = r_o_dlen;
    assign o_view_valid_len = r_o_vlen;

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_D1W || r_state == S_LDW || r_state == S_GW
                            || r_state == S_MW || r_state == S_WW))
        else $error("divider result outside a wait step");

    a_bad_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ok) |-> (r_dlen == '0 && r_vlen == '0 && !r_rok))
        else $error("lengths not zero for a degenerate configuration");

endmodule

FILE: sv/ldm_div.sv
// Restoring divider, one quotient bit per cycle.
module ldm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ldm_pkg::t_div_req  i_req,
    output ldm_pkg::t_div_rsp  o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [ldm_pkg::DIV_CW-1:0]  r_cnt;
    logic [ldm_pkg::DIV_NW-1:0]  r_num;
    logic [ldm_pkg::DIV_DW-1:0]  r_den;
    logic [ldm_pkg::DIV_DW-1:0]  r_rem;
    logic [ldm_pkg::DIV_NW-1:0]  r_quo;
    logic [ldm_pkg::DIV_DW:0]    w_trial;
    logic [ldm_pkg::DIV_DW:0]    w_diff;
    logic                        w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[ldm_pkg::DIV_NW-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ldm_pkg::DIV_CW'(ldm_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ldm_pkg::DIV_DW-1:0] : w_trial[ldm_pkg::DIV_DW-1:0];
            r_quo <= {r_quo[ldm_pkg::DIV_NW-2:0], w_ge};
            r_num <= {r_num[ldm_pkg::DIV_NW-2:0], 1'b0};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: sv/ldm_store.sv
// Dot position memory: one write port, one registered read port.
module ldm_store (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [ldm_pkg::AW-1:0]  i_wr_addr,
    input  ldm_pkg::t_dot           i_wr_data,
    input  logic                    i_rd_en,
    input  logic [ldm_pkg::AW-1:0]  i_rd_addr,
    output ldm_pkg::t_dot           o_rd_data
);

    ldm_pkg::t_dot r_mem [ldm_pkg::DOT_DEPTH];
    ldm_pkg::t_dot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
